/* hdl/rhc_pkg.sv */
// ----------------------------------------------------------------------------
// rhc_pkg: shared constants and types for the RGB/HLS converter
// Field widths, fixed-point scaling and the payload structs of both channels.
// ----------------------------------------------------------------------------
`default_nettype none
package rhc_pkg;
  localparam int FracBits    = 12;
  localparam int HueFracBits = 6;
  localparam int FracOne     = 1 << FracBits;
  localparam int HueDeg      = 1 << HueFracBits;
  localparam int HueFull     = 360 * HueDeg;
  localparam int Sixty       = 60 * HueDeg;

  localparam logic ActRgbToHls = 1'b0;
  localparam logic ActHlsToRgb = 1'b1;

  typedef struct packed {
    logic        action;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic [14:0] hue_in;
    logic [12:0] lightness_in;
    logic [12:0] saturation_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [14:0] hue_out;
    logic [12:0] lightness_out;
    logic [12:0] saturation_out;
  } pix_out_t;
endpackage
`default_nettype wire

/* hdl/rhc_stream_if.sv */
// ----------------------------------------------------------------------------
// rhc_stream_if: valid/ready channel
// Carries one payload per transfer.
// ----------------------------------------------------------------------------
`default_nettype none
interface rhc_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/rgb_hls_converter_core.sv */
// ----------------------------------------------------------------------------
// rgb_hls_converter_core: pixel converter between 8-bit RGB and HLS
// The pipeline has 21 register stages: five setup stages, fifteen divider
// stages and the output register. Throughput is one pixel per clock; the
// pipeline advances whenever its output stage is empty or is being taken,
// so a stall freezes every stage.
// Synchronous active-high reset clears all valid bits; data needs none.
// ----------------------------------------------------------------------------
`default_nettype none
module rgb_hls_converter_core
  import rhc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  rhc_stream_if.sink      pix_in,
  rhc_stream_if.source    pix_out
);

  // The pipeline is a chain of stages sharing one enable. Saturation and hue
  // have data-dependent divisors and are produced by a restoring divider,
  // one quotient bit per stage, so each of those stages holds one compare and
  // subtract per lane. Both quotients stay below 2^15. Lightness and the RGB
  // bytes divide by constants and use reciprocal multiplication instead.
  localparam int NQ        = 15;          // quotient bits resolved
  localparam int NPRE      = 5;           // setup stages
  localparam int NSTG      = NPRE + NQ + 1;
  localparam int DW        = 24;          // dividend width
  // ceil(2^28/255): exact floor division by 255 for dividends below 1.12e6.
  localparam int RecipLig  = 1052689;
  // ceil(2^16/15): exact floor division by 15 for dividends below 4681.
  localparam int RecipByte = 4370;

  typedef struct packed {
    logic               act;
    logic               achrom;
    logic [12:0]        lig;
    logic [2:0][7:0]    byt;   // red, green, blue
    logic [1:0][DW-1:0] num;   // dividends: saturation, hue
    logic [1:0][9:0]    den;
    logic [1:0][14:0]   quo;
  } stage_t;

  logic [NSTG-1:0] vld;
  logic            adv;
  assign adv = !vld[NSTG-1] || pix_out.ready;
  assign pix_in.ready = adv;

  // ---------------- setup stage 0: min/max, HLS clamps ----------------------
  pix_in_t     d;
  logic [7:0]  mx, mn;
  logic [12:0] cl, cs;
  logic [14:0] hm;
  assign d = pix_in.data;
  always_comb begin
    mx = d.red_in; mn = d.red_in;
    if (d.green_in > mx) mx = d.green_in;
    if (d.blue_in  > mx) mx = d.blue_in;
    if (d.green_in < mn) mn = d.green_in;
    if (d.blue_in  < mn) mn = d.blue_in;
    cl = (d.lightness_in > 13'(FracOne)) ? 13'(FracOne) : d.lightness_in;
    cs = (d.saturation_in > 13'(FracOne)) ? 13'(FracOne) : d.saturation_in;
    hm = (d.hue_in >= 15'(HueFull)) ? d.hue_in - 15'(HueFull) : d.hue_in;
  end

  typedef struct packed {
    logic        act;
    logic [7:0]  r, g, b, mx, mn;
    logic [12:0] l, s;
    logic [14:0] h;
  } s0_t;
  s0_t s0;
  always_ff @(posedge clk) begin
    if (adv) s0 <= '{d.action, d.red_in, d.green_in, d.blue_in, mx, mn, cl, cs, hm};
  end

  // ---------------- stage 1: hue numerator, m2 products --------------------
  // With zero saturation m1 and m2 both equal l*q, so the ramp below gives
  // floor(l*255/q) on every channel without a separate path.
  typedef struct packed {
    logic              act;
    logic              achrom;
    logic [8:0]        sum;
    logic [7:0]        dd;
    logic signed [19:0] t;
    logic [25:0]       m2;
    logic [25:0]       l2;
    logic [14:0]       h;
  } s1_t;
  s1_t s1;
  logic signed [19:0] t1;
  logic [7:0]        dd1;
  logic [25:0]       ls1, m21;
  always_comb begin
    dd1 = s0.mx - s0.mn;
    if (s0.r == s0.mx)
      t1 = 20'sd60 * ($signed({12'd0, s0.g}) - $signed({12'd0, s0.b}));
    else if (s0.g == s0.mx)
      t1 = 20'sd120 * $signed({12'd0, dd1})
         + 20'sd60 * ($signed({12'd0, s0.b}) - $signed({12'd0, s0.r}));
    else
      t1 = 20'sd240 * $signed({12'd0, dd1})
         + 20'sd60 * ($signed({12'd0, s0.r}) - $signed({12'd0, s0.g}));
    ls1 = 26'(s0.l) * 26'(s0.s);
    if ({s0.l, 1'b0} <= 14'(FracOne))
      m21 = 26'(s0.l) * 26'(FracOne) + ls1;
    else
      m21 = (26'(s0.l) + 26'(s0.s)) * 26'(FracOne) - ls1;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s1.act    <= s0.act;
      s1.achrom <= (s0.mx == s0.mn);
      s1.sum    <= 9'(s0.mx) + 9'(s0.mn);
      s1.dd     <= dd1;
      s1.t      <= (t1 < 0) ? t1 + 20'sd360 * $signed({12'd0, dd1}) : t1;
      s1.m2     <= m21;
      s1.l2     <= 26'(s0.l) * 26'(2 * FracOne);
      s1.h      <= s0.h;
    end
  end

  // ---------------- stage 2: ramp numerators and dividends -----------------
  // For each channel the ramp value is formed as num, in units of
  // 1/(Sixty*q*q); byte = floor(num*255 / (Sixty*q*q)). Both directions are
  // computed for every pixel and the output stage keeps the one asked for.
  function automatic logic [35:0] ramp_num(input logic [25:0] m1,
                                           input logic [25:0] m2,
                                           input logic signed [16:0] hin);
    logic signed [16:0] h;
    logic [25:0]        span;
    begin
      h = hin;
      if (h < 0) h = h + 17'sd23040;
      if (h >= 17'sd23040) h = h - 17'sd23040;
      span = m2 - m1;
      if (h < 17'(Sixty))
        ramp_num = 36'(m1) * 36'(Sixty) + 36'(span) * 36'(h[14:0]);
      else if (h < 17'(180 * HueDeg))
        ramp_num = 36'(m2) * 36'(Sixty);
      else if (h < 17'(240 * HueDeg))
        ramp_num = 36'(m1) * 36'(Sixty)
                 + 36'(span) * 36'(15'(240 * HueDeg) - h[14:0]);
      else
        ramp_num = 36'(m1) * 36'(Sixty);
    end
  endfunction

  typedef struct packed {
    logic               act;
    logic               achrom;
    logic [19:0]        ly;    // lightness dividend with its two low bits dropped
    logic [2:0][35:0]   rn;    // ramp numerators: red, green, blue
    logic [1:0][DW-1:0] num;
    logic [1:0][9:0]    den;
  } s2_t;
  s2_t s2;
  logic [25:0] m1_2;
  logic [8:0]  sden;
  assign m1_2 = s1.l2 - s1.m2;
  assign sden = (s1.sum <= 9'd255) ? s1.sum : 9'd510 - s1.sum;
  always_ff @(posedge clk) begin
    if (adv) begin
      s2.act    <= s1.act;
      s2.achrom <= s1.achrom;
      // (2*sum*q + 510) / 1020 is floor((2048*sum + 127) / 255).
      s2.ly     <= 20'(s1.sum) * 20'(FracOne / 2) + 20'd127;
      s2.num[0] <= DW'(s1.dd) * DW'(2 * FracOne) + DW'(sden);
      s2.den[0] <= {1'b0, sden} << 1;
      s2.num[1] <= DW'(s1.t) * DW'(2 * HueDeg) + DW'(s1.dd);
      s2.den[1] <= {1'b0, s1.dd, 1'b0};
      s2.rn[0]  <= ramp_num(m1_2, s1.m2, $signed({2'b0, s1.h}) + 17'sd7680);
      s2.rn[1]  <= ramp_num(m1_2, s1.m2, $signed({2'b0, s1.h}));
      s2.rn[2]  <= ramp_num(m1_2, s1.m2, $signed({2'b0, s1.h}) - 17'sd7680);
    end
  end

  // ---------------- stage 3: lightness, first half of the bytes ------------
  // Sixty*q*q is 15 * 2^32, so each byte is a shift by 32 of num*255
  // followed by a division by 15 in the next stage.
  typedef struct packed {
    logic               act;
    logic               achrom;
    logic [12:0]        lig;
    logic [2:0][11:0]   y;
    logic [1:0][DW-1:0] num;
    logic [1:0][9:0]    den;
  } s3_t;
  s3_t s3;
  logic [40:0]      lp;
  logic [2:0][43:0] bp;
  always_comb begin
    lp = 41'(s2.ly) * 41'(RecipLig);
    for (int k = 0; k < 3; k++)
      bp[k] = 44'(s2.rn[k]) * 44'(255);
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s3.act    <= s2.act;
      s3.achrom <= s2.achrom;
      s3.lig    <= lp[40:28];
      for (int k = 0; k < 3; k++)
        s3.y[k] <= bp[k][43:32];
      s3.num    <= s2.num;
      s3.den    <= s2.den;
    end
  end

  // ---------------- stage 4: bytes by reciprocal of 15 ---------------------
  // y never exceeds 15*255, so the quotient never needs clipping at 255.
  stage_t           s4;
  logic [2:0][23:0] yp;
  always_comb begin
    for (int k = 0; k < 3; k++)
      yp[k] = 24'(s3.y[k]) * 24'(RecipByte);
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s4.act    <= s3.act;
      s4.achrom <= s3.achrom;
      s4.lig    <= s3.lig;
      for (int k = 0; k < 3; k++)
        s4.byt[k] <= yp[k][23:16];
      s4.num    <= s3.num;
      s4.den    <= s3.den;
      s4.quo    <= '0;
    end
  end

  // ---------------- divider stages: one quotient bit per stage -------------
  // Achromatic pixels bring a zero hue divisor; their quotients are discarded.
  stage_t dq [NQ+1];
  assign dq[0] = s4;

  for (genvar i = 0; i < NQ; i++) begin : g_div
    localparam int B = NQ - 1 - i;
    stage_t nx;
    always_comb begin
      nx = dq[i];
      for (int k = 0; k < 2; k++) begin
        if ((DW'(dq[i].den[k]) << B) <= dq[i].num[k]) begin
          nx.num[k]    = dq[i].num[k] - (DW'(dq[i].den[k]) << B);
          nx.quo[k][B] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) dq[i+1] <= nx;
    end
  end

  // ---------------- output stage: wrap and select --------------------------
  stage_t      f;
  logic [14:0] hq;
  assign f = dq[NQ];
  always_comb begin
    hq = (f.quo[1] >= 15'(HueFull)) ? f.quo[1] - 15'(HueFull) : f.quo[1];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      if (f.act == ActHlsToRgb)
        pix_out.data <= '{f.byt[0], f.byt[1], f.byt[2], 15'd0, 13'd0, 13'd0};
      else if (f.achrom)
        pix_out.data <= '{8'd0, 8'd0, 8'd0, 15'd0, f.lig, 13'd0};
      else
        pix_out.data <= '{8'd0, 8'd0, 8'd0, hq, f.lig, f.quo[0][12:0]};
    end
  end

  // ---------------- valid chain ---------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], pix_in.valid};
    end
  end
  assign pix_out.valid = vld[NSTG-1];

  // ---------------- assertions ----------------------------------------------
  a_hold: assert property (@(posedge clk) disable iff (rst)
    pix_out.valid && !pix_out.ready |=> pix_out.valid && $stable(pix_out.data))
    else $error("result changed while stalled");
  a_hue: assert property (@(posedge clk) disable iff (rst)
    pix_out.valid |-> pix_out.data.hue_out < 15'(HueFull))
    else $error("hue out of range");
  a_frac: assert property (@(posedge clk) disable iff (rst)
    pix_out.valid |-> pix_out.data.lightness_out <= 13'(FracOne)
                   && pix_out.data.saturation_out <= 13'(FracOne))
    else $error("fraction above one");

endmodule
`default_nettype wire
